@@ sv/vgm_pkg.sv @@
// Package for the voxel greedy mesher: widths, states and helper types.
// Depends on nothing.
`timescale 1ns / 1ps

package vgm_pkg;

   localparam int unsigned MaxSizeDefault = 8;
   localparam int unsigned MatWidth       = 16;
   localparam int unsigned SizeWidth      = 4;
   localparam int unsigned PosWidth       = 3;
   localparam int unsigned CoordWidth     = 4;

   localparam logic [1:0] CsrSizeX = 2'd0;
   localparam logic [1:0] CsrSizeY = 2'd1;
   localparam logic [1:0] CsrSizeZ = 2'd2;

   localparam logic ReqWrite = 1'b0;
   localparam logic ReqMesh  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD_A,
      ST_BUILD_B,
      ST_BUILD_W,
      ST_SCAN,
      ST_GROW_W,
      ST_GROW_H,
      ST_CLEAR,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic                  quad_valid;
      logic [CoordWidth-1:0] origin_x;
      logic [CoordWidth-1:0] origin_y;
      logic [CoordWidth-1:0] origin_z;
      logic [CoordWidth-1:0] extent_w;
      logic [CoordWidth-1:0] extent_h;
      logic [MatWidth-1:0]   face_material;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic                 req_type;
      logic [PosWidth-1:0]  pos_x;
      logic [PosWidth-1:0]  pos_y;
      logic [PosWidth-1:0]  pos_z;
      logic [MatWidth-1:0]  material;
      logic [1:0]           axis;
      logic                 back_face;
      logic [SizeWidth-1:0] plane;
   } req_type_t_type;

endpackage

@@ sv/vgm_if.sv @@
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps

interface vgm_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/voxel_greedy_mesher.sv @@
// Voxel greedy mesher top level: voxel store, face mask and sweep sequencer.
// Depends on vgm_pkg and vgm_if.
//
// channel | direction | payload
// req     | in        | write voxel or mesh slice
// rsp     | out       | one quad, or empty-slice marker
// csr     | in        | size_x/y/z writes
//
// A voxel write goes to the store as it is taken. A slice builds the mask cell by
// cell over one store read port (BUILD_A, BUILD_B, BUILD_W), then scans it; an
// empty cell takes a SCAN and a GROW_W step. A quad is found by SCAN, grown along
// u (GROW_W) and along v (GROW_H), cleared (CLEAR) and emitted (EMIT); EMPTY ends
// the slice. Reset starts a clearing pass over all 2^(3*clog2(MAX_SIZE)) store
// entries (512 by default) with no item taken. No item is taken while a slice is in
// work; a waiting result stalls the sweep at its next quad.
`timescale 1ns / 1ps

module voxel_greedy_mesher
   import vgm_pkg::*;
#(
   parameter int unsigned MAX_SIZE = MaxSizeDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   vgm_if.sink                  req,
   vgm_if.source                rsp,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [SizeWidth-1:0] csr_data
);

   localparam int unsigned CW     = $clog2(MAX_SIZE);
   localparam int unsigned DEPTH  = 1 << (3 * CW);
   localparam int unsigned MDEPTH = 1 << (2 * CW);
   localparam int unsigned AW     = $clog2(DEPTH);
   localparam int unsigned MW     = $clog2(MDEPTH);
   localparam int unsigned NW     = CW + 1;

   logic [MatWidth-1:0] store_mem [DEPTH];
   logic [MatWidth-1:0] mask_mem  [MDEPTH];

   state_type state_ff, state_in;
   logic [SizeWidth-1:0] size_ff [3];
   logic [AW:0]          wipe_ff;
   logic                 wiping;

   logic [1:0]           d_ff, u_ff, v_ff;
   logic                 back_ff;
   logic [NW-1:0]        p_ff, su_ff, sv_ff, sd_ff;
   logic [NW-1:0]        i_ff, j_ff, i_in, j_in;
   logic [NW-1:0]        w_ff, h_ff, k_ff, l_ff;
   logic [MatWidth-1:0]  a_ff, mat_ff;
   logic                 found_ff;
   rsp_type              rsp_ff, rsp_in;
   rsp_type              pend_ff, quad_in;
   logic                 rsp_valid_ff;
   logic                 slot_free, rsp_load;
   logic [NW-1:0]        org [3];

   logic [AW-1:0]        st_raddr;
   logic [MatWidth-1:0]  st_rdata;
   logic [MW-1:0]        mk_raddr, mk_waddr;
   logic [MatWidth-1:0]  mk_rdata, mk_wdata;
   logic                 mk_we;

   logic                 st_we;
   logic [AW-1:0]        st_waddr;
   logic [MatWidth-1:0]  st_wdata;
   logic                 req_fire;

   logic [MatWidth-1:0]  a_val, b_val, m_val;
   logic                 w_more, h_more;
   logic                 grow_w_hit, grow_h_hit;
   logic                 last_cell;
   logic                 scan_end;

   function automatic logic [NW-1:0] clampz(input logic [SizeWidth-1:0] s);
      logic [NW-1:0] r;
      if (s == '0) r = NW'(1);
      else if (32'(s) > MAX_SIZE) r = NW'(MAX_SIZE);
      else r = NW'(s);
      return r;
   endfunction

   function automatic logic [AW-1:0] vaddr(input logic [1:0] d, input logic [1:0] u,
         input logic [NW-1:0] cd, input logic [NW-1:0] cu, input logic [NW-1:0] cv);
      logic [CW-1:0] c [3];
      c[d] = cd[CW-1:0];
      c[u] = cu[CW-1:0];
      c[2'd3 - d - u] = cv[CW-1:0];
      return {c[2], c[1], c[0]};
   endfunction

   function automatic logic [MW-1:0] maddr(input logic [NW-1:0] i, input logic [NW-1:0] j);
      return {j[CW-1:0], i[CW-1:0]};
   endfunction

   assign wiping = !wipe_ff[AW];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= SizeWidth'(8);
         size_ff[1] <= SizeWidth'(8);
         size_ff[2] <= SizeWidth'(8);
      end else if (csr_write) begin
         unique case (csr_index)
            CsrSizeX: size_ff[0] <= csr_data;
            CsrSizeY: size_ff[1] <= csr_data;
            CsrSizeZ: size_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Voxel store: one write and one registered read port.
   assign req.ready = (state_ff == ST_IDLE) && !wiping;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      st_we    = 1'b0;
      st_waddr = {CW'(req.data.pos_z), CW'(req.data.pos_y), CW'(req.data.pos_x)};
      st_wdata = req.data.material;
      if (wiping) begin
         st_we    = 1'b1;
         st_waddr = wipe_ff[AW-1:0];
         st_wdata = '0;
      end else if (req_fire && req.data.req_type == ReqWrite) begin
         st_we = (32'(req.data.pos_x) < MAX_SIZE) && (32'(req.data.pos_y) < MAX_SIZE)
            && (32'(req.data.pos_z) < MAX_SIZE);
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_waddr] <= st_wdata;
      st_rdata <= store_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (mk_we) mask_mem[mk_waddr] <= mk_wdata;
      mk_rdata <= mask_mem[mk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) wipe_ff <= '0;
      else if (wiping) wipe_ff <= wipe_ff + (AW+1)'(1);
   end

   // Read addresses are issued from the state ahead of the one that uses the registered data.
   always_comb begin
      st_raddr = vaddr(d_ff, u_ff, p_ff, i_ff, j_ff);
      if (state_ff == ST_BUILD_A) st_raddr = vaddr(d_ff, u_ff, p_ff - NW'(1), i_ff, j_ff);
   end

   always_comb begin
      unique case (state_ff)
         ST_SCAN:   mk_raddr = maddr(i_ff + NW'(1), j_ff);
         ST_GROW_W: mk_raddr = grow_w_hit ? maddr(i_ff + w_ff + NW'(1), j_ff)
                                          : maddr(i_ff, j_ff + NW'(1));
         ST_GROW_H: mk_raddr = (k_ff + NW'(1) == w_ff) ? maddr(i_ff, j_ff + h_ff + NW'(1))
                                                       : maddr(i_ff + k_ff + NW'(1), j_ff + h_ff);
         default:   mk_raddr = maddr(i_ff, j_ff);
      endcase
   end

   always_comb begin
      a_val = (p_ff != '0) ? a_ff : '0;
      b_val = (p_ff < sd_ff) ? st_rdata : '0;
      if (back_ff) m_val = (a_val == '0) ? b_val : '0;
      else         m_val = (b_val == '0) ? a_val : '0;
      w_more     = (i_ff + w_ff) < su_ff;
      h_more     = (j_ff + h_ff) < sv_ff;
      grow_w_hit = w_more && (mk_rdata == mat_ff);
      grow_h_hit = (mk_rdata == mat_ff);
      mk_we    = (state_ff == ST_BUILD_W) || (state_ff == ST_CLEAR);
      mk_waddr = (state_ff == ST_CLEAR) ? maddr(i_ff + k_ff, j_ff + l_ff) : maddr(i_ff, j_ff);
      mk_wdata = (state_ff == ST_CLEAR) ? '0 : m_val;
   end

   assign last_cell = (i_ff + NW'(1) >= su_ff) && (j_ff + NW'(1) >= sv_ff);

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      if (i_ff + w_ff >= su_ff) begin
         i_in = '0;
         j_in = j_ff + NW'(1);
      end else begin
         i_in = i_ff + w_ff;
      end
      scan_end = (j_in >= sv_ff);
   end

   // The newest quad is held back until the next one or the end of the slice.
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign rsp_load  = slot_free && ((state_ff == ST_EMIT && found_ff) || state_ff == ST_EMPTY);

   always_comb begin
      org[0] = '0;
      org[1] = '0;
      org[2] = '0;
      org[d_ff] = p_ff;
      org[u_ff] = i_ff;
      org[v_ff] = j_ff;
      quad_in = '0;
      quad_in.quad_valid    = 1'b1;
      quad_in.origin_x      = CoordWidth'(org[0]);
      quad_in.origin_y      = CoordWidth'(org[1]);
      quad_in.origin_z      = CoordWidth'(org[2]);
      quad_in.extent_w      = CoordWidth'(w_ff);
      quad_in.extent_h      = CoordWidth'(h_ff);
      quad_in.face_material = mat_ff;
      rsp_in = pend_ff;
      if (!found_ff) rsp_in = '0;
      if (state_ff == ST_EMPTY) rsp_in.last = 1'b1;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire && req.data.req_type == ReqMesh) begin
            if (req.data.axis == 2'd3 ||
                  req.data.plane > SizeWidth'(clampz(size_ff[req.data.axis])))
               state_in = ST_EMPTY;
            else state_in = ST_BUILD_A;
         end
         ST_BUILD_A: state_in = ST_BUILD_B;
         ST_BUILD_B: state_in = ST_BUILD_W;
         ST_BUILD_W: state_in = last_cell ? ST_SCAN : ST_BUILD_A;
         ST_SCAN:    state_in = ST_GROW_W;
         ST_GROW_W: begin
            if (mat_ff == '0) state_in = scan_end ? ST_EMPTY : ST_SCAN;
            else if (!grow_w_hit) state_in = h_more ? ST_GROW_H : ST_CLEAR;
         end
         ST_GROW_H: begin
            if (!grow_h_hit) state_in = ST_CLEAR;
            else if (k_ff + NW'(1) == w_ff && !(j_ff + h_ff + NW'(1) < sv_ff))
               state_in = ST_CLEAR;
         end
         ST_CLEAR: if (k_ff + NW'(1) == w_ff && l_ff + NW'(1) == h_ff) state_in = ST_EMIT;
         ST_EMIT:  if (slot_free) state_in = scan_end ? ST_EMPTY : ST_SCAN;
         ST_EMPTY: if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               d_ff    <= req.data.axis;
               u_ff    <= (req.data.axis == 2'd2) ? 2'd0 : req.data.axis + 2'd1;
               v_ff    <= (req.data.axis == 2'd0) ? 2'd2 : req.data.axis - 2'd1;
               back_ff <= req.data.back_face;
               p_ff    <= NW'(req.data.plane);
               i_ff    <= '0;
               j_ff    <= '0;
               w_ff    <= NW'(1);
               found_ff <= 1'b0;
            end
            ST_BUILD_A: begin
               su_ff <= clampz(size_ff[u_ff]);
               sv_ff <= clampz(size_ff[v_ff]);
               sd_ff <= clampz(size_ff[d_ff]);
            end
            ST_BUILD_B: a_ff <= st_rdata;
            ST_BUILD_W: begin
               if (last_cell) begin
                  i_ff <= '0;
                  j_ff <= '0;
               end else if (i_ff + NW'(1) >= su_ff) begin
                  i_ff <= '0;
                  j_ff <= j_ff + NW'(1);
               end else i_ff <= i_ff + NW'(1);
            end
            ST_SCAN: begin
               w_ff <= NW'(1);
               k_ff <= '0;
               l_ff <= '0;
               h_ff <= NW'(1);
            end
            ST_GROW_W: begin
               if (mat_ff == '0) begin
                  i_ff <= i_in;
                  j_ff <= j_in;
               end else if (grow_w_hit) begin
                  w_ff <= w_ff + NW'(1);
               end
            end
            ST_GROW_H: begin
               if (grow_h_hit) begin
                  if (k_ff + NW'(1) == w_ff) begin
                     k_ff <= '0;
                     h_ff <= h_ff + NW'(1);
                  end else k_ff <= k_ff + NW'(1);
               end else k_ff <= '0;
            end
            ST_CLEAR: begin
               if (k_ff + NW'(1) == w_ff) begin
                  k_ff <= '0;
                  l_ff <= l_ff + NW'(1);
               end else k_ff <= k_ff + NW'(1);
            end
            ST_EMIT: if (slot_free) begin
               pend_ff  <= quad_in;
               found_ff <= 1'b1;
               i_ff     <= i_in;
               j_ff     <= j_in;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= rsp_in;
   end

   // Material under the scan pointer, latched when a new run begins.
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN) mat_ff <= mask_mem[maddr(i_ff, j_ff)];
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("item taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
   a_no_wipe_accept: assert property (@(posedge clock) disable iff (reset)
      wiping |-> !req.ready) else $error("item taken during clear");
`endif

endmodule

@@ sim/voxel_greedy_mesher_tb.sv @@
// Testbench for the voxel greedy mesher: drives voxel writes and slice
// requests, predicts every quad with its own greedy sweep and checks them.
// Depends on vgm_pkg, vgm_if and the voxel_greedy_mesher top level.
`timescale 1ns / 1ps

module voxel_greedy_mesher_tb;
   import vgm_pkg::*;

   localparam int unsigned Dim = 8;
   localparam int unsigned WatchLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CsrSizeX;
   logic [SizeWidth-1:0] csr_data = '0;

   vgm_if #(.payload_type(req_type_t_type)) req_ch ();
   vgm_if #(.payload_type(rsp_type)) rsp_ch ();

   voxel_greedy_mesher #(.MAX_SIZE(Dim)) u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   logic [MatWidth-1:0] grid [Dim*Dim*Dim];
   logic [MatWidth-1:0] mask [Dim*Dim];
   int unsigned extent [3];
   rsp_type pending_quads [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit hold_recv = 1'b0;
   int errors = 0;
   int quads_seen = 0;
   int slices_sent = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   typedef struct {
      req_type_t_type item;
      bit has_ref;
      rsp_type ref_rsp;
   } stim_row_type;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int unsigned clamp_extent(logic [SizeWidth-1:0] value);
      if (value == 0) return 1;
      if (value > Dim) return Dim;
      return 32'(value);
   endfunction

   function automatic logic [MatWidth-1:0] grid_at(int unsigned c [3]);
      return grid[(c[2]*Dim + c[1])*Dim + c[0]];
   endfunction

   task automatic predict_item(req_type_t_type it);
      int unsigned d, u, v, p, su, sv, w, h, n;
      int unsigned c [3];
      logic [MatWidth-1:0] a, b, mat;
      bit stop;
      int count;
      rsp_type q;
      count = 0;
      if (it.req_type == ReqWrite) begin
         grid[(it.pos_z*Dim + it.pos_y)*Dim + it.pos_x] = it.material;
         return;
      end
      d = it.axis;
      p = it.plane;
      if (d < 3 && p <= extent[d]) begin
         u = (d + 1) % 3;
         v = (d + 2) % 3;
         su = extent[u];
         sv = extent[v];
         for (int j = 0; j < sv; j++) begin
            for (int i = 0; i < su; i++) begin
               a = '0;
               b = '0;
               c[u] = i;
               c[v] = j;
               if (p > 0) begin
                  c[d] = p - 1;
                  a = grid_at(c);
               end
               if (p < extent[d]) begin
                  c[d] = p;
                  b = grid_at(c);
               end
               if (it.back_face) mask[j*su + i] = (a == 0) ? b : '0;
               else mask[j*su + i] = (b == 0) ? a : '0;
            end
         end
         n = 0;
         for (int j = 0; j < sv; j++) begin
            for (int i = 0; i < su; ) begin
               mat = mask[n];
               if (mat == 0) begin
                  i++;
                  n++;
                  continue;
               end
               for (w = 1; i + w < su && mask[n + w] == mat; w++) ;
               for (h = 1; j + h < sv; h++) begin
                  stop = 1'b0;
                  for (int k = 0; k < w; k++)
                     if (mask[n + k + h*su] != mat) stop = 1'b1;
                  if (stop) break;
               end
               c[d] = p;
               c[u] = i;
               c[v] = j;
               q = '0;
               q.quad_valid = 1'b1;
               q.origin_x = CoordWidth'(c[0]);
               q.origin_y = CoordWidth'(c[1]);
               q.origin_z = CoordWidth'(c[2]);
               q.extent_w = CoordWidth'(w);
               q.extent_h = CoordWidth'(h);
               q.face_material = mat;
               pending_quads.push_back(q);
               count++;
               for (int l = 0; l < h; l++)
                  for (int k = 0; k < w; k++) mask[n + k + l*su] = '0;
               i += w;
               n += w;
            end
         end
      end
      if (count == 0) begin
         q = '0;
         pending_quads.push_back(q);
      end
      pending_quads[$].last = 1'b1;
   endtask

   task automatic send_item(req_type_t_type it);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_item(it);
      items_sent++;
      if (it.req_type == ReqMesh) slices_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_quads.size() != 0) @(posedge clock);
      repeat (Dim*Dim*4) @(posedge clock);
   endtask

   task automatic write_size(logic [1:0] idx, logic [SizeWidth-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      extent[idx] = clamp_extent(value);
      @(posedge clock);
   endtask

   function automatic req_type_t_type voxel_item(int x, int y, int z, int m);
      req_type_t_type it;
      it = '0;
      it.req_type = ReqWrite;
      it.pos_x = PosWidth'(x);
      it.pos_y = PosWidth'(y);
      it.pos_z = PosWidth'(z);
      it.material = MatWidth'(m);
      return it;
   endfunction

   function automatic req_type_t_type slice_item(int d, int bf, int p);
      req_type_t_type it;
      it = '0;
      it.req_type = ReqMesh;
      it.axis = 2'(d);
      it.back_face = 1'(bf);
      it.plane = SizeWidth'(p);
      return it;
   endfunction

   function automatic req_type_t_type random_item(bit dense);
      req_type_t_type it;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      it = raw[$bits(req_type_t_type)-1:0];
      if (dense) begin
         it.req_type = ($urandom_range(99) < 80) ? ReqWrite : ReqMesh;
         it.material = MatWidth'($urandom_range(3));
         if ($urandom_range(9) == 0) it.material = MatWidth'($urandom);
         if ($urandom_range(9) != 0) it.axis = 2'($urandom_range(2));
         if ($urandom_range(9) != 0) it.plane = SizeWidth'($urandom_range(Dim));
      end
      return it;
   endfunction

   task automatic random_phase(int unsigned items, int unsigned s_pct, int unsigned r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < items; i++) send_item(random_item($urandom_range(9) != 0));
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !hold_recv && !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            quads_seen++;
            if (pending_quads.size() == 0) begin
               errors++;
               $display("%0t: unexpected result %p", $time, rsp_ch.data);
            end else begin
               if (rsp_ch.data !== pending_quads[0]) begin
                  errors++;
                  $display("%0t: mismatch expected %p actual %p", $time,
                     pending_quads[0], rsp_ch.data);
               end
               void'(pending_quads.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      rsp_type empty_rsp;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      foreach (grid[i]) grid[i] = '0;
      foreach (extent[i]) extent[i] = Dim;
      empty_rsp = '0;
      empty_rsp.last = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_size(CsrSizeX, 4'd8);
      write_size(CsrSizeY, 4'd8);
      write_size(CsrSizeZ, 4'd8);

      row.has_ref = 1'b1;
      row.ref_rsp = empty_rsp;
      row.item = slice_item(0, 0, 0);
      rows.push_back(row);
      row.item = slice_item(3, 0, 1);
      rows.push_back(row);
      row.item = slice_item(1, 1, 9);
      rows.push_back(row);
      row.item = slice_item(2, 0, 15);
      rows.push_back(row);
      row.has_ref = 1'b0;
      row.item = voxel_item(0, 0, 0, 16'hFFFF);
      rows.push_back(row);
      row.item = voxel_item(7, 7, 7, 16'h0001);
      rows.push_back(row);
      row.item = voxel_item(1, 0, 0, 16'hFFFF);
      rows.push_back(row);
      row.item = voxel_item(0, 1, 0, 16'hFFFF);
      rows.push_back(row);
      row.item = voxel_item(1, 1, 0, 16'hFFFF);
      rows.push_back(row);
      for (int d = 0; d < 3; d++) begin
         for (int bf = 0; bf < 2; bf++) begin
            row.item = slice_item(d, bf, bf ? 0 : 1);
            rows.push_back(row);
         end
         row.item = slice_item(d, 0, 8);
         rows.push_back(row);
      end
      row.item = slice_item(2, 1, 7);
      rows.push_back(row);
      row.item = voxel_item(7, 7, 7, 16'h0000);
      rows.push_back(row);
      row.item = slice_item(2, 0, 8);
      rows.push_back(row);
      foreach (rows[i]) begin
         if (rows[i].has_ref) begin
            predict_item(rows[i].item);
            if (pending_quads[$] !== rows[i].ref_rsp) begin
               errors++;
               $display("%0t: mismatch expected %p actual %p", $time,
                  rows[i].ref_rsp, pending_quads[$]);
            end
            void'(pending_quads.pop_back());
         end
         send_item(rows[i].item);
      end
      wait_drained();

      send_idle_pct = 0;
      fork
         begin
            hold_recv = 1'b1;
            repeat (400) @(posedge clock);
            hold_recv = 1'b0;
         end
         for (int i = 0; i < 20; i++) send_item(random_item(1'b1));
      join
      wait_drained();

      random_phase(140, 21, 51);
      write_size(CsrSizeX, 4'd1);
      write_size(CsrSizeY, 4'd0);
      write_size(CsrSizeZ, 4'd15);
      random_phase(60, 51, 21);
      write_size(CsrSizeX, 4'd3);
      write_size(CsrSizeY, 4'd5);
      write_size(CsrSizeZ, 4'd2);
      random_phase(100, 51, 21);
      write_size(CsrSizeX, 4'd8);
      write_size(CsrSizeY, 4'd8);
      write_size(CsrSizeZ, 4'd8);
      random_phase(140, 0, 0);

      $display("tb: %0d items sent, %0d slices, %0d results checked over several sizes",
         items_sent, slices_sent, quads_seen);
      if (errors == 0 && pending_quads.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
